/* hdl/sfb_pkg.sv */
// Package for the softmax forward/backward core.
// Holds the sequencer state type, fixed field widths, register codes and the exp table.
// No dependencies.
package sfb_pkg;

   localparam int VALUE_W   = 16;
   localparam int RESULT_W  = 17;
   localparam int INDEX_W   = 6;
   localparam int LEN_W     = 7;
   localparam int SUM_W     = 40;
   localparam int ZSUM_W    = 23;
   localparam int TERM_W    = 17;
   localparam int QUO_W     = 17;
   localparam int DIVIDEND_W = 33;

   // log2(e) in Q.15.
   localparam logic [15:0] LOG2E_Q15 = 16'd47274;

   localparam logic [0:0] REG_VECTOR_LENGTH = 1'b0;
   localparam logic [0:0] MODE_FORWARD  = 1'b0;
   localparam logic [0:0] MODE_BACKWARD = 1'b1;

   typedef enum logic [3:0] {
      S_LOAD,
      S_BACC,
      S_F1_RD,
      S_F1_MUL,
      S_F1_ACC,
      S_F2_RD,
      S_F2_MUL,
      S_F2_TERM,
      S_F2_DIV,
      S_F2_OUT,
      S_B_RD,
      S_B_MUL,
      S_B_OUT
   } state_type;

   // 2^(-i/16) in Q1.16.
   function automatic logic [TERM_W-1:0] pow2_frac(input logic [3:0] idx);
      logic [TERM_W-1:0] r;
      begin
         case (idx)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd62757;
            4'd2:  r = 17'd60097;
            4'd3:  r = 17'd57549;
            4'd4:  r = 17'd55109;
            4'd5:  r = 17'd52773;
            4'd6:  r = 17'd50535;
            4'd7:  r = 17'd48393;
            4'd8:  r = 17'd46341;
            4'd9:  r = 17'd44376;
            4'd10: r = 17'd42495;
            4'd11: r = 17'd40693;
            4'd12: r = 17'd38968;
            4'd13: r = 17'd37316;
            4'd14: r = 17'd35734;
            default: r = 17'd34219;
         endcase
         return r;
      end
   endfunction

endpackage

/* hdl/sfb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module sfb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sfb_div.sv */
// Restoring divider, one quotient bit per cycle, for the probability normalization.
// Depends on sfb_pkg for widths. The quotient is known to fit in QUO_W bits.
module sfb_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sfb_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [sfb_pkg::ZSUM_W-1:0]        divisor,
   output logic                              busy,
   output logic                              done,
   output logic [sfb_pkg::QUO_W-1:0]         quotient
);

   localparam int REM_W  = sfb_pkg::ZSUM_W + 1;
   localparam int STEP_W = $clog2(sfb_pkg::QUO_W + 1);

   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [sfb_pkg::QUO_W-1:0]   low_ff, low_in;
   logic [sfb_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [sfb_pkg::ZSUM_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            trial;
   logic                        fits;

   always_comb begin
      trial   = {rem_ff[REM_W-2:0], low_ff[sfb_pkg::QUO_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // The upper dividend bits are below the divisor, so they seed the remainder.
         rem_in  = REM_W'(dividend[sfb_pkg::DIVIDEND_W-1:sfb_pkg::QUO_W]);
         low_in  = dividend[sfb_pkg::QUO_W-1:0];
         dvs_in  = divisor;
         step_in = STEP_W'(sfb_pkg::QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial - {1'b0, dvs_ff} : trial;
         quo_in  = {quo_ff[sfb_pkg::QUO_W-2:0], fits};
         low_in  = {low_ff[sfb_pkg::QUO_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without a running division");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff != '0) else $error("divider step count ran out while busy");

endmodule

/* hdl/softmax_forward_backward_core.sv */
// Softmax forward/backward core. Loading: beats are taken in S_LOAD, and each backward beat
// also passes through S_BACC before the next one is taken. Forward finish: a sum pass (read,
// multiply, accumulate), then a normalize pass that runs the bit-serial divider per element.
// Backward finish: per element, one read each of the probability and gradient RAMs.
// Synchronous active-high reset clears control state; the stores are undefined until written.
module softmax_forward_backward_core #(
   parameter int MAX_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] result_value, [22:17] element_index, [23] zero
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam logic [sfb_pkg::LEN_W-1:0] MAX_LEN_V = sfb_pkg::LEN_W'(MAX_LEN);
   localparam int PROD_W = 58;

   sfb_pkg::state_type state_ff, state_in;

   logic [sfb_pkg::LEN_W-1:0]          vector_length_ff;
   logic [CNT_W-1:0]                   load_count_ff, load_count_in;
   logic signed [sfb_pkg::VALUE_W-1:0] running_max_ff, running_max_in;
   logic signed [sfb_pkg::SUM_W-1:0]   running_sum_ff, running_sum_in;
   logic                               load_mode_ff, load_mode_in;
   logic                               finish_ff, finish_in;
   logic signed [sfb_pkg::VALUE_W-1:0] dy_ff, dy_in;
   logic [IDX_W-1:0]                   pass_idx_ff, pass_idx_in;
   logic [16:0]                        u_ff, u_in;
   logic signed [PROD_W-1:0]           prod_ff, prod_in;
   logic                               out_valid_ff, out_valid_in;
   logic [sfb_pkg::RESULT_W-1:0]       out_value_ff, out_value_in;
   logic [sfb_pkg::INDEX_W-1:0]        out_index_ff, out_index_in;
   logic                               out_last_ff, out_last_in;

   // Control decoded from the state.
   logic accept, emit, slot_free, div_start, prob_we, pass_last;
   logic cfg_write;

   logic [CNT_W-1:0] eff_len, base_cnt, cnt_next;
   logic [IDX_W-1:0] load_idx, last_idx;
   logic             restart_m, done_load, mode_in;
   logic signed [sfb_pkg::VALUE_W-1:0] x_in, max_base;

   logic [sfb_pkg::VALUE_W-1:0] elem_rdata, prob_rdata, grad_rdata, prob_wdata;
   logic [IDX_W-1:0]            prob_raddr;

   logic                          div_busy, div_done;
   logic [sfb_pkg::QUO_W-1:0]     div_quo;
   logic [sfb_pkg::DIVIDEND_W-1:0] dividend;
   logic [sfb_pkg::TERM_W-1:0]    term;
   logic [6:0]                    exp_k;
   logic signed [16:0]            tdiff;
   logic [31:0]                   tprod;
   logic signed [32:0]            mac;
   logic signed [40:0]            bdiff;
   logic signed [PROD_W-1:0]      rounded;
   logic signed [25:0]            dx_full;
   logic signed [sfb_pkg::VALUE_W-1:0] dx_sat;

   // Effective length: zero acts as one, anything above MAX_LEN as MAX_LEN.
   always_comb begin
      if (vector_length_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (vector_length_ff > MAX_LEN_V) begin
         eff_len = CNT_W'(MAX_LEN);
      end else begin
         eff_len = CNT_W'(vector_length_ff);
      end
      last_idx = IDX_W'(eff_len - CNT_W'(1));
   end

   assign mode_in   = req_tuser[0];
   assign x_in      = $signed(req_tdata);
   assign restart_m = (load_count_ff != '0) && (mode_in != load_mode_ff);
   assign base_cnt  = restart_m ? '0 : load_count_ff;
   assign load_idx  = base_cnt[IDX_W-1:0];
   assign cnt_next  = base_cnt + CNT_W'(1);
   assign done_load = cnt_next == eff_len;
   assign max_base  = restart_m ? 16'sh8000 : running_max_ff;
   assign pass_last = pass_idx_ff == last_idx;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == sfb_pkg::REG_VECTOR_LENGTH);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfb_pkg::S_LOAD: begin
            if (req_tvalid) begin
               if (mode_in == sfb_pkg::MODE_BACKWARD) begin
                  state_in = sfb_pkg::S_BACC;
               end else if (done_load) begin
                  state_in = sfb_pkg::S_F1_RD;
               end
            end
         end
         sfb_pkg::S_BACC:    state_in = finish_ff ? sfb_pkg::S_B_RD : sfb_pkg::S_LOAD;
         sfb_pkg::S_F1_RD:   state_in = sfb_pkg::S_F1_MUL;
         sfb_pkg::S_F1_MUL:  state_in = sfb_pkg::S_F1_ACC;
         sfb_pkg::S_F1_ACC:  state_in = pass_last ? sfb_pkg::S_F2_RD : sfb_pkg::S_F1_RD;
         sfb_pkg::S_F2_RD:   state_in = sfb_pkg::S_F2_MUL;
         sfb_pkg::S_F2_MUL:  state_in = sfb_pkg::S_F2_TERM;
         sfb_pkg::S_F2_TERM: state_in = sfb_pkg::S_F2_DIV;
         sfb_pkg::S_F2_DIV: begin
            if (div_done) begin
               state_in = sfb_pkg::S_F2_OUT;
            end
         end
         sfb_pkg::S_F2_OUT: begin
            if (slot_free) begin
               state_in = pass_last ? sfb_pkg::S_LOAD : sfb_pkg::S_F2_RD;
            end
         end
         sfb_pkg::S_B_RD:    state_in = sfb_pkg::S_B_MUL;
         sfb_pkg::S_B_MUL:   state_in = sfb_pkg::S_B_OUT;
         sfb_pkg::S_B_OUT: begin
            if (slot_free) begin
               state_in = pass_last ? sfb_pkg::S_LOAD : sfb_pkg::S_B_RD;
            end
         end
         default:            state_in = sfb_pkg::S_LOAD;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      emit       = 1'b0;
      div_start  = 1'b0;
      prob_we    = 1'b0;
      prob_raddr = pass_idx_ff;
      unique case (state_ff)
         sfb_pkg::S_LOAD: begin
            req_tready = 1'b1;
            prob_raddr = load_idx;
         end
         sfb_pkg::S_F2_TERM: div_start = 1'b1;
         sfb_pkg::S_F2_OUT: begin
            emit    = slot_free;
            prob_we = slot_free;
         end
         sfb_pkg::S_B_OUT:  emit = slot_free;
         default: begin
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Exp term: u = t*log2(e) in Q.10, term = 2^(-frac) >> int.
   assign tdiff = {running_max_ff[15], running_max_ff} - {elem_rdata[15], elem_rdata};
   assign tprod = tdiff[15:0] * sfb_pkg::LOG2E_Q15;
   assign exp_k = u_ff[16:10];
   assign term  = (exp_k >= 7'd17) ? '0 : (sfb_pkg::pow2_frac(u_ff[9:6]) >> exp_k[4:0]);
   assign dividend = {term, 16'b0} +
                     sfb_pkg::DIVIDEND_W'(running_sum_ff[sfb_pkg::ZSUM_W-1:1]);

   assign prob_wdata = div_quo[16] ? 16'hFFFF : div_quo[15:0];

   // Backward arithmetic.
   assign mac   = $signed(dy_ff) * $signed({1'b0, prob_rdata});
   assign bdiff = $signed({{9{grad_rdata[15]}}, grad_rdata, 16'b0}) -
                  $signed({running_sum_ff[sfb_pkg::SUM_W-1], running_sum_ff});
   assign rounded = prod_ff + $signed(PROD_W'(64'h8000_0000));
   assign dx_full = rounded[PROD_W-1:32];
   always_comb begin
      if (dx_full > 26'sd32767) begin
         dx_sat = 16'sh7FFF;
      end else if (dx_full < -26'sd32768) begin
         dx_sat = 16'sh8000;
      end else begin
         dx_sat = dx_full[15:0];
      end
   end

   // Datapath registers.
   always_comb begin
      load_count_in  = load_count_ff;
      running_max_in = running_max_ff;
      running_sum_in = running_sum_ff;
      load_mode_in   = load_mode_ff;
      finish_in      = finish_ff;
      dy_in          = dy_ff;
      pass_idx_in    = pass_idx_ff;
      u_in           = u_ff;
      prod_in        = prod_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_value_in   = out_value_ff;
      out_index_in   = out_index_ff;
      out_last_in    = out_last_ff;

      if (accept) begin
         load_mode_in   = mode_in;
         load_count_in  = cnt_next;
         pass_idx_in    = '0;
         // A mode switch abandons the partial vector, including its running sum.
         running_sum_in = restart_m ? '0 : running_sum_ff;
         if (mode_in == sfb_pkg::MODE_FORWARD) begin
            running_max_in = (x_in > max_base) ? x_in : max_base;
         end else begin
            running_max_in = max_base;
            dy_in          = x_in;
            finish_in      = done_load;
         end
      end

      unique case (state_ff) inside
         sfb_pkg::S_BACC: begin
            running_sum_in = running_sum_ff + sfb_pkg::SUM_W'(mac);
         end
         sfb_pkg::S_F1_MUL, sfb_pkg::S_F2_MUL: u_in = tprod[31:15];
         sfb_pkg::S_F1_ACC: begin
            running_sum_in = running_sum_ff + sfb_pkg::SUM_W'(term);
            pass_idx_in    = pass_last ? '0 : pass_idx_ff + IDX_W'(1);
         end
         sfb_pkg::S_B_MUL: prod_in = bdiff * $signed({1'b0, prob_rdata});
         default: begin
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
         out_index_in = sfb_pkg::INDEX_W'(pass_idx_ff);
         out_last_in  = pass_last;
         if (state_ff == sfb_pkg::S_F2_OUT) begin
            out_value_in = {1'b0, prob_wdata};
         end else begin
            out_value_in = {dx_sat[15], dx_sat};
         end
         pass_idx_in = pass_idx_ff + IDX_W'(1);
         if (pass_last) begin
            load_count_in  = '0;
            running_max_in = 16'sh8000;
            running_sum_in = '0;
         end
      end

      if (cfg_write) begin
         load_count_in  = '0;
         running_max_in = 16'sh8000;
         running_sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sfb_pkg::S_LOAD;
         vector_length_ff <= sfb_pkg::LEN_W'(64);
         load_count_ff    <= '0;
         running_max_ff   <= 16'sh8000;
         running_sum_ff   <= '0;
         load_mode_ff     <= sfb_pkg::MODE_FORWARD;
         finish_ff        <= 1'b0;
         pass_idx_ff      <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         load_count_ff  <= load_count_in;
         running_max_ff <= running_max_in;
         running_sum_ff <= running_sum_in;
         load_mode_ff   <= load_mode_in;
         finish_ff      <= finish_in;
         pass_idx_ff    <= pass_idx_in;
         out_valid_ff   <= out_valid_in;
         if (cfg_write) begin
            vector_length_ff <= csr_pwdata[sfb_pkg::LEN_W-1:0];
         end
      end
      dy_ff        <= dy_in;
      u_ff         <= u_in;
      prod_ff      <= prod_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   sfb_ram #(.WIDTH(sfb_pkg::VALUE_W), .DEPTH(MAX_LEN)) u_element_store (
      .clock   (clock),
      .wr_en   (accept && (mode_in == sfb_pkg::MODE_FORWARD)),
      .wr_addr (load_idx),
      .wr_data (req_tdata),
      .rd_addr (pass_idx_ff),
      .rd_data (elem_rdata)
   );

   sfb_ram #(.WIDTH(sfb_pkg::VALUE_W), .DEPTH(MAX_LEN)) u_probability_store (
      .clock   (clock),
      .wr_en   (prob_we),
      .wr_addr (pass_idx_ff),
      .wr_data (prob_wdata),
      .rd_addr (prob_raddr),
      .rd_data (prob_rdata)
   );

   sfb_ram #(.WIDTH(sfb_pkg::VALUE_W), .DEPTH(MAX_LEN)) u_gradient_store (
      .clock   (clock),
      .wr_en   (accept && (mode_in == sfb_pkg::MODE_BACKWARD)),
      .wr_addr (load_idx),
      .wr_data (req_tdata),
      .rd_addr (pass_idx_ff),
      .rd_data (grad_rdata)
   );

   sfb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (running_sum_ff[sfb_pkg::ZSUM_W-1:0]),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_index_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == sfb_pkg::REG_VECTOR_LENGTH) ?
                       32'(vector_length_ff) : '0;

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfb_pkg::S_LOAD |-> !div_busy) else $error("divider busy while loading");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfb_pkg::S_LOAD |-> load_count_ff < eff_len)
      else $error("load count reached the vector length while loading");
   a_prob_emit: assert property (@(posedge clock) disable iff (reset)
      prob_we |=> rsp_tvalid) else $error("stored probability was not presented");
   a_sum_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfb_pkg::S_F2_TERM |-> running_sum_ff != '0)
      else $error("normalization with a zero sum");

endmodule

/* sim/softmax_forward_backward_core_checker.sv */
// Checker for the softmax forward/backward core: watches the request, result and register
// ports, keeps its own model of the layer and compares every result beat in order.
// Depends on sfb_pkg for field widths and codes.
module softmax_forward_backward_core_checker #(
   parameter int MAX_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [sfb_pkg::RESULT_W-1:0] value;
      logic [sfb_pkg::INDEX_W-1:0]  index;
      logic                         last;
   } softmax_beat_type;

   // 2^(-i/16) in Q1.16.
   localparam int unsigned EXP2_FRAC[16] = '{
      65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
      46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219
   };

   softmax_beat_type             expected_beats[$];
   logic [sfb_pkg::LEN_W-1:0]    length_reg;
   logic [15:0]                  logit_mem [MAX_LEN];
   logic [15:0]                  prob_mem [MAX_LEN];
   logic [15:0]                  grad_mem [MAX_LEN];
   int                           loaded;
   logic signed [15:0]           peak_logit;
   longint                       grad_dot;
   logic                         vector_mode;

   assign pending = expected_beats.size();

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int unsigned active_length();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_LEN) return MAX_LEN;
      return length_reg;
   endfunction

   function automatic longint unsigned exp_term(input logic [15:0] logit);
      longint unsigned gap, scaled, whole;
      gap    = longint'(peak_logit) - longint'($signed(logit));
      scaled = (gap * 47274) >> 15;
      whole  = scaled >> 10;
      if (whole >= 17) return 0;
      return EXP2_FRAC[(scaled >> 6) & 15] >> whole;
   endfunction

   task automatic clear_vector();
      loaded     = 0;
      peak_logit = -16'sd32768;
      grad_dot   = 0;
   endtask

   // Takes one accepted request beat and queues the results it completes.
   task automatic predict_softmax(input logic mode, input logic [15:0] value);
      longint unsigned  terms[MAX_LEN];
      longint unsigned  zsum, prob;
      longint           diff, dx;
      int unsigned      len, slot;
      softmax_beat_type beat;
      len = active_length();
      if (loaded > 0 && mode != vector_mode) clear_vector();
      vector_mode = mode;
      slot = loaded % MAX_LEN;
      if (mode == sfb_pkg::MODE_FORWARD) begin
         logit_mem[slot] = value;
         if ($signed(value) > peak_logit) peak_logit = $signed(value);
      end else begin
         grad_mem[slot] = value;
         grad_dot += longint'($signed(value)) * longint'(prob_mem[slot]);
      end
      loaded++;
      if (loaded < len) return;
      zsum = 0;
      for (int i = 0; i < len; i++) begin
         terms[i] = exp_term(logit_mem[i]);
         zsum += terms[i];
      end
      for (int i = 0; i < len; i++) begin
         if (mode == sfb_pkg::MODE_FORWARD) begin
            prob = (terms[i] * 65536 + zsum / 2) / zsum;
            if (prob > 65535) prob = 65535;
            prob_mem[i] = prob[15:0];
            beat.value  = prob[16:0];
         end else begin
            diff = longint'($signed(grad_mem[i])) * 65536 - grad_dot;
            dx   = (diff * longint'(prob_mem[i]) + (longint'(1) << 31)) >>> 32;
            if (dx > 32767) dx = 32767;
            if (dx < -32768) dx = -32768;
            beat.value = dx[16:0];
         end
         beat.index = i[sfb_pkg::INDEX_W-1:0];
         beat.last  = (i == len - 1);
         expected_beats.push_back(beat);
      end
      clear_vector();
   endtask

   always @(posedge clock) begin
      softmax_beat_type want;
      if (reset) begin
         fail_count  = 0;
         length_reg  = 7'd64;
         vector_mode = sfb_pkg::MODE_FORWARD;
         for (int i = 0; i < MAX_LEN; i++) prob_mem[i] = '0;
         clear_vector();
         expected_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat %h", rsp_tdata));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_tdata[16:0] !== want.value)
                  report_mismatch($sformatf("result_value %h, expected %h (index %0d)",
                                            rsp_tdata[16:0], want.value, want.index));
               if (rsp_tdata[22:17] !== want.index)
                  report_mismatch($sformatf("element_index %0d, expected %0d",
                                            rsp_tdata[22:17], want.index));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("tlast %b, expected %b at index %0d",
                                            rsp_tlast, want.last, want.index));
               if (rsp_tdata[23] !== 1'b0)
                  report_mismatch("padding bit of result tdata is set");
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == sfb_pkg::REG_VECTOR_LENGTH) begin
            length_reg = csr_pwdata[sfb_pkg::LEN_W-1:0];
            clear_vector();
         end
         if (req_tvalid && req_tready) predict_softmax(req_tuser[0], req_tdata);
      end
   end

endmodule

/* sim/softmax_forward_backward_core_tb.sv */
// Testbench top for the softmax forward/backward core: clock, reset, stimulus and verdict.
// Depends on sfb_pkg, the core and softmax_forward_backward_core_checker.
module softmax_forward_backward_core_tb;

   localparam logic [0:0] REG_SPARE = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   bit          calm = 1'b0;
   bit          hold_go = 1'b0;
   bit          hold_taken = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   softmax_forward_backward_core u_dut (.*);

   softmax_forward_backward_core_checker u_checker (.*);

   task automatic send_beat(input logic mode, input logic [15:0] value);
      if (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Lets the core drain completely before a register write.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
      drain();
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [15:0] pick_value();
      if ($urandom_range(1)) return 16'($urandom_range(2047)) - 16'd1024;
      return 16'($urandom);
   endfunction

   task automatic send_vector(input logic mode, input int count);
      for (int i = 0; i < count; i++) send_beat(mode, pick_value());
   endtask

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 27;
         end
      end
   end

   initial begin
      #(8 * 3_000_000);
      $display("softmax_forward_backward_core verification failed");
      $finish;
   end

   initial begin
      int len;
      int sent;
      int part;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A full-length forward vector first, so every probability entry is written.
      send_beat(sfb_pkg::MODE_FORWARD, 16'h7FFF);
      send_beat(sfb_pkg::MODE_FORWARD, 16'h8000);
      send_beat(sfb_pkg::MODE_FORWARD, 16'h0000);
      send_beat(sfb_pkg::MODE_FORWARD, 16'hFFFF);
      for (int i = 4; i < 64; i++) send_beat(sfb_pkg::MODE_FORWARD, 16'h7FFF - 16'(i * 40));
      // An oversize length saturates to a full vector.
      write_reg(sfb_pkg::REG_VECTOR_LENGTH, 32'd127);
      send_beat(sfb_pkg::MODE_BACKWARD, 16'h7FFF);
      send_beat(sfb_pkg::MODE_BACKWARD, 16'h8000);
      for (int i = 2; i < 64; i++) send_beat(sfb_pkg::MODE_BACKWARD, pick_value());

      // A length of zero behaves as one.
      write_reg(sfb_pkg::REG_VECTOR_LENGTH, 32'd0);
      send_beat(sfb_pkg::MODE_FORWARD, 16'h8000);
      send_beat(sfb_pkg::MODE_BACKWARD, 16'h8000);
      send_beat(sfb_pkg::MODE_BACKWARD, 16'h7FFF);

      // An oversize length saturates; the partial vector is dropped by the next length write,
      // while a write to the spare address changes nothing.
      write_reg(sfb_pkg::REG_VECTOR_LENGTH, 32'd127);
      send_vector(sfb_pkg::MODE_FORWARD, 5);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      write_reg(sfb_pkg::REG_VECTOR_LENGTH, 32'd3);
      send_beat(sfb_pkg::MODE_FORWARD, 16'h7FFF);
      send_beat(sfb_pkg::MODE_FORWARD, 16'h8000);
      send_beat(sfb_pkg::MODE_FORWARD, 16'h7FFF);
      // Mode switch in the middle of a vector starts a new one.
      send_vector(sfb_pkg::MODE_BACKWARD, 2);
      send_beat(sfb_pkg::MODE_FORWARD, 16'h0400);
      send_vector(sfb_pkg::MODE_BACKWARD, 3);

      sent = 0;
      while (sent < 75) begin
         case ($urandom_range(19)) inside
            [0:1]:   len = $urandom_range(21, 40);
            [2:4]:   len = $urandom_range(9, 20);
            default: len = $urandom_range(1, 8);
         endcase
         write_reg(sfb_pkg::REG_VECTOR_LENGTH, len);
         repeat ($urandom_range(1, 3)) begin
            if (sent >= 75) break;
            calm = sent >= 20 && sent < 45;
            if (sent >= 50) hold_go = 1'b1;
            if ($urandom_range(9) == 0 && len > 1) begin
               part = $urandom_range(1, len - 1);
               send_vector(sfb_pkg::MODE_BACKWARD, part);
               sent += part;
            end
            send_vector(sfb_pkg::MODE_FORWARD, len);
            if ($urandom_range(9) == 0 && len > 1) begin
               part = $urandom_range(1, len - 1);
               send_vector(sfb_pkg::MODE_FORWARD, part);
               sent += part;
            end
            send_vector(sfb_pkg::MODE_BACKWARD, len);
            sent += 2 * len;
         end
      end
      calm = 1'b0;
      drain();

      if (fail_count == 0) begin
         $display("softmax_forward_backward_core verification clean");
      end else begin
         $display("softmax_forward_backward_core verification failed");
      end
      $finish;
   end

endmodule
